FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the display encoder RTL.
// Clocked on aclk, disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every active clock edge.
`define DSE_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("display encoder check failed");

// Non-overlapping implication from antecedent to consequent.
`define DSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("display encoder check failed");

`endif

FILE: rtl/core/dse_pkg.sv
// Package for the decimal seven-segment display encoder.
// Request codes, font and column tables, divide-by-ten constants.
// No dependencies.
package dse_pkg;

    localparam int DIGIT_COUNT   = 8;
    localparam int WORD_COUNT    = 8;
    localparam int ALL_REG_COUNT = 6;
    localparam int WORD_W        = 32;
    localparam int IDX_W         = $clog2(WORD_COUNT);
    localparam int DIG_W         = $clog2(DIGIT_COUNT);

    localparam logic [WORD_W-1:0] ALL_ON_WORD = 32'h007f_ffff;

    // floor(n / 10) == (n * RECIP10) >> RECIP_SHIFT for every 32-bit n
    localparam logic [31:0] RECIP10     = 32'hcccc_cccd;
    localparam int          RECIP_SHIFT = 35;

    typedef enum logic [1:0] {
        REQ_SHOW   = 2'd0,
        REQ_BIT    = 2'd1,
        REQ_ALL    = 2'd2,
        REQ_UNUSED = 2'd3
    } req_e_t;

    function automatic logic [6:0] seg_font(input logic [3:0] digit);
        logic [6:0] f;
        f = 7'h00;
        case (digit)
            4'd0: f = 7'h3f;
            4'd1: f = 7'h06;
            4'd2: f = 7'h5b;
            4'd3: f = 7'h4f;
            4'd4: f = 7'h66;
            4'd5: f = 7'h6d;
            4'd6: f = 7'h7d;
            4'd7: f = 7'h07;
            4'd8: f = 7'h7f;
            4'd9: f = 7'h6f;
            default: f = 7'h00;
        endcase
        return f;
    endfunction

    function automatic logic [4:0] col_p(input logic [DIG_W-1:0] k);
        logic [4:0] c;
        c = 5'd0;
        case (k)
            3'd0: c = 5'd10;
            3'd1: c = 5'd8;
            3'd2: c = 5'd6;
            3'd3: c = 5'd13;
            3'd4: c = 5'd15;
            3'd5: c = 5'd17;
            3'd6: c = 5'd19;
            3'd7: c = 5'd21;
            default: c = 5'd0;
        endcase
        return c;
    endfunction

    function automatic logic [4:0] col_q(input logic [DIG_W-1:0] k);
        logic [4:0] c;
        c = 5'd0;
        case (k)
            3'd0: c = 5'd9;
            3'd1: c = 5'd7;
            3'd2: c = 5'd5;
            3'd3: c = 5'd14;
            3'd4: c = 5'd16;
            3'd5: c = 5'd18;
            3'd6: c = 5'd20;
            3'd7: c = 5'd22;
            default: c = 5'd0;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/core/decimal_segment_display_encoder.sv
// Decimal seven-segment display encoder: display word store, digit sequencer, write-out.
// Depends on dse_pkg and assert_macros.svh.
//
//   channel  | ports                                               | handshake
//   ---------+-----------------------------------------------------+------------------
//   request  | s_req_type s_number s_com_index s_seg_index s_bit_value | s_valid/s_ready
//   writes   | m_reg_index m_reg_data m_last                       | m_valid/m_ready
//
// Show number: accept, then per digit a multiply step and a remainder and
// placement step through one divide-by-ten unit, then 8 writes.
// Set bit: 8 writes after accept; all on/off: 6 writes. One request at a time.
// Writes leave through an output register; m_ready low holds the sequencer.
// Synchronous active-low reset clears the display words and control state.
module decimal_segment_display_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_number,
    input  logic [3:0]  s_com_index,
    input  logic [5:0]  s_seg_index,
    input  logic        s_bit_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_reg_index,
    output logic [31:0] m_reg_data,
    output logic        m_last
);

`include "assert_macros.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIG,
        ST_EMIT
    } state_t;

    localparam logic [dse_pkg::IDX_W-1:0] LAST_STORE =
        dse_pkg::IDX_W'(dse_pkg::WORD_COUNT - 1);
    localparam logic [dse_pkg::IDX_W-1:0] LAST_ALL =
        dse_pkg::IDX_W'(dse_pkg::ALL_REG_COUNT - 1);
    localparam logic [dse_pkg::DIG_W-1:0] LAST_DIG =
        dse_pkg::DIG_W'(dse_pkg::DIGIT_COUNT - 1);

    state_t                          state_reg;
    logic [dse_pkg::WORD_W-1:0]      words_reg [dse_pkg::WORD_COUNT];
    logic [31:0]                     num_reg;
    logic [63:0]                     prod_reg;
    logic [dse_pkg::DIG_W-1:0]       dig_cnt_reg;
    logic [dse_pkg::IDX_W-1:0]       emit_cnt_reg;
    logic                            all_mode_reg;
    logic                            all_on_reg;
    logic                            m_valid_reg;
    logic [2:0]                      m_reg_index_reg;
    logic [31:0]                     m_reg_data_reg;
    logic                            m_last_reg;

    logic                            accept;
    logic                            bit_ok;
    logic [dse_pkg::IDX_W-1:0]       bit_word;
    logic [4:0]                      bit_pos;
    logic [31:0]                     quot;
    logic [31:0]                     rem_full;
    logic [6:0]                      font;
    logic [4:0]                      pos_p;
    logic [4:0]                      pos_q;
    logic                            load_out;
    logic [dse_pkg::IDX_W-1:0]       emit_end;

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_reg_index = m_reg_index_reg;
    assign m_reg_data  = m_reg_data_reg;
    assign m_last      = m_last_reg;

    assign bit_ok   = (s_com_index != 4'd0) && (s_com_index <= 4'd8)
                   && (s_seg_index != 6'd0) && (s_seg_index <= 6'd32);
    assign bit_word = dse_pkg::IDX_W'(s_com_index - 4'd1);
    assign bit_pos  = 5'(s_seg_index - 6'd1);

    assign quot     = 32'(prod_reg >> dse_pkg::RECIP_SHIFT);
    assign rem_full = num_reg - ((quot << 3) + (quot << 1));
    assign font     = dse_pkg::seg_font(rem_full[3:0]);
    assign pos_p    = dse_pkg::col_p(dig_cnt_reg);
    assign pos_q    = dse_pkg::col_q(dig_cnt_reg);

    assign load_out = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign emit_end = all_mode_reg ? LAST_ALL : LAST_STORE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            dig_cnt_reg     <= '0;
            emit_cnt_reg    <= '0;
            all_mode_reg    <= 1'b0;
            all_on_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
            m_reg_index_reg <= '0;
            m_reg_data_reg  <= '0;
            m_last_reg      <= 1'b0;
            num_reg         <= '0;
            prod_reg        <= '0;
            for (int i = 0; i < dse_pkg::WORD_COUNT; i++) begin
                words_reg[i] <= '0;
            end
        end else begin
            if (m_valid_reg && m_ready && !load_out) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        num_reg      <= s_number;
                        dig_cnt_reg  <= '0;
                        emit_cnt_reg <= '0;
                        all_on_reg   <= s_bit_value;
                        all_mode_reg <= 1'b0;
                        unique case (dse_pkg::req_e_t'(s_req_type))
                            dse_pkg::REQ_SHOW: state_reg <= ST_MUL;
                            dse_pkg::REQ_BIT: begin
                                if (bit_ok) begin
                                    words_reg[bit_word][bit_pos] <= s_bit_value;
                                end
                                state_reg <= ST_EMIT;
                            end
                            dse_pkg::REQ_ALL: begin
                                all_mode_reg <= 1'b1;
                                state_reg    <= ST_EMIT;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_MUL: begin
                    prod_reg  <= 64'(num_reg) * 64'(dse_pkg::RECIP10);
                    state_reg <= ST_DIG;
                end
                ST_DIG: begin
                    words_reg[1][pos_p] <= font[0];
                    words_reg[2][pos_p] <= font[1];
                    words_reg[3][pos_p] <= font[2];
                    words_reg[4][pos_q] <= font[3];
                    words_reg[3][pos_q] <= font[4];
                    words_reg[1][pos_q] <= font[5];
                    words_reg[2][pos_q] <= font[6];
                    num_reg     <= quot;
                    dig_cnt_reg <= dig_cnt_reg + 1'b1;
                    state_reg   <= (dig_cnt_reg == LAST_DIG) ? ST_EMIT : ST_MUL;
                end
                ST_EMIT: begin
                    if (load_out) begin
                        m_valid_reg     <= 1'b1;
                        m_reg_index_reg <= 3'(emit_cnt_reg);
                        m_reg_data_reg  <= all_mode_reg
                                         ? (all_on_reg ? dse_pkg::ALL_ON_WORD : '0)
                                         : words_reg[emit_cnt_reg];
                        m_last_reg      <= (emit_cnt_reg == emit_end);
                        emit_cnt_reg    <= emit_cnt_reg + 1'b1;
                        if (emit_cnt_reg == emit_end) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `DSE_ASSERT_NEXT(a_busy_after_accept,
        accept && (s_req_type != dse_pkg::REQ_UNUSED), !s_ready)
    `DSE_ASSERT_NEXT(a_show_starts_digits,
        accept && (s_req_type == dse_pkg::REQ_SHOW),
        (state_reg == ST_MUL) && (dig_cnt_reg == '0))
    `DSE_ASSERT_ALWAYS(a_last_on_final_reg,
        !(m_valid && m_last) || (m_reg_index == 3'd7) || (m_reg_index == 3'd5))
    `DSE_ASSERT_ALWAYS(a_no_load_while_idle,
        (state_reg != ST_IDLE) || !load_out)

endmodule

FILE: tb/sv/tb.sv
// Testbench for decimal_segment_display_encoder: drives display requests and checks
// every register write against a local model of the eight display words.
// Depends on dse_pkg and the encoder RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_GAP        = 17;

    typedef struct packed {
        logic [2:0]  idx;
        logic [31:0] data;
        logic        last;
    } reg_write_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_req_type;
    logic [31:0] s_number;
    logic [3:0]  s_com_index;
    logic [5:0]  s_seg_index;
    logic        s_bit_value;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_reg_index;
    logic [31:0] m_reg_data;
    logic        m_last;

    logic [31:0] shown_words [8];
    reg_write_t  pending_writes [$];
    int          mismatch_count = 0;
    int          stall_count = 0;
    int          rx_hold_cycles = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;

    const logic [6:0] digit_glyph [10] = '{7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66,
                                           7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f};
    const logic [4:0] col_a_pos [8] = '{5'd10, 5'd8, 5'd6, 5'd13, 5'd15, 5'd17, 5'd19, 5'd21};
    const logic [4:0] col_d_pos [8] = '{5'd9, 5'd7, 5'd5, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22};

    decimal_segment_display_encoder DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_number    (s_number),
        .s_com_index (s_com_index),
        .s_seg_index (s_seg_index),
        .s_bit_value (s_bit_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_reg_index (m_reg_index),
        .m_reg_data  (m_reg_data),
        .m_last      (m_last)
    );

    always #6 aclk = ~aclk;

    function automatic void predict_display_writes(input dse_pkg::req_e_t kind,
                                                   input logic [31:0] num,
                                                   input logic [3:0] com, input logic [5:0] seg,
                                                   input logic bv);
        logic [31:0] rest;
        logic [6:0]  g;
        logic [4:0]  pa;
        logic [4:0]  pd;
        rest = num;
        case (kind)
            dse_pkg::REQ_SHOW: begin
                for (int k = 0; k < dse_pkg::DIGIT_COUNT; k++) begin
                    g    = digit_glyph[rest % 10];
                    rest = rest / 10;
                    pa   = col_a_pos[k];
                    pd   = col_d_pos[k];
                    shown_words[1][pa] = g[0];
                    shown_words[2][pa] = g[1];
                    shown_words[3][pa] = g[2];
                    shown_words[4][pd] = g[3];
                    shown_words[3][pd] = g[4];
                    shown_words[1][pd] = g[5];
                    shown_words[2][pd] = g[6];
                end
            end
            dse_pkg::REQ_BIT: begin
                if (com >= 1 && com <= dse_pkg::WORD_COUNT && seg >= 1 && seg <= 32)
                    shown_words[com - 1][seg - 1] = bv;
            end
            dse_pkg::REQ_ALL: begin
                for (int i = 0; i < dse_pkg::ALL_REG_COUNT; i++)
                    pending_writes.push_back('{i[2:0], bv ? dse_pkg::ALL_ON_WORD : 32'h0,
                                               i == dse_pkg::ALL_REG_COUNT - 1});
            end
            default: ;
        endcase
        if (kind == dse_pkg::REQ_SHOW || kind == dse_pkg::REQ_BIT) begin
            for (int i = 0; i < dse_pkg::WORD_COUNT; i++)
                pending_writes.push_back('{i[2:0], shown_words[i],
                                           i == dse_pkg::WORD_COUNT - 1});
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic send_request(input dse_pkg::req_e_t kind, input logic [31:0] num,
                                input logic [3:0] com, input logic [5:0] seg, input logic bv);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= kind;
        s_number    <= num;
        s_com_index <= com;
        s_seg_index <= seg;
        s_bit_value <= bv;
        do @(posedge aclk); while (!s_ready);
        predict_display_writes(kind, num, com, seg, bv);
    endtask

    task automatic send_random_request();
        int               sel;
        dse_pkg::req_e_t  kind;
        logic [31:0]      num;
        logic [3:0]       com;
        logic [5:0]       seg;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            kind = dse_pkg::REQ_SHOW;
        else if (sel < 80)
            kind = dse_pkg::REQ_BIT;
        else if (sel < 93)
            kind = dse_pkg::REQ_ALL;
        else
            kind = dse_pkg::REQ_UNUSED;
        case ($urandom_range(0, 2))
            0: num = $urandom;
            1: num = $urandom_range(0, 99999999);
            default: num = $urandom_range(0, 999);
        endcase
        if ($urandom_range(0, 9) < 8) begin
            com = $urandom_range(1, 8);
            seg = $urandom_range(1, 32);
        end else begin
            com = $urandom_range(0, 15);
            seg = $urandom_range(0, 63);
        end
        send_request(kind, num, com, seg, $urandom_range(0, 1));
    endtask

    task automatic drain_writes();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_writes.size() != 0);
    endtask

    task automatic test_show_number();
        send_request(dse_pkg::REQ_SHOW, 32'd0, 4'd0, 6'd0, 1'b0);
        send_request(dse_pkg::REQ_SHOW, 32'd12345678, 4'd15, 6'd63, 1'b1);
        send_request(dse_pkg::REQ_SHOW, 32'd87654321, 4'd0, 6'd0, 1'b0);
        send_request(dse_pkg::REQ_SHOW, 32'd99999999, 4'd0, 6'd0, 1'b0);
        send_request(dse_pkg::REQ_SHOW, 32'd100000000, 4'd0, 6'd0, 1'b0);
        send_request(dse_pkg::REQ_SHOW, 32'hffff_ffff, 4'd0, 6'd0, 1'b0);
        send_request(dse_pkg::REQ_SHOW, 32'd9, 4'd0, 6'd0, 1'b0);
        drain_writes();
    endtask

    task automatic test_segment_bits();
        send_request(dse_pkg::REQ_BIT, 32'h0, 4'd1, 6'd1, 1'b1);
        send_request(dse_pkg::REQ_BIT, 32'hffff_ffff, 4'd8, 6'd32, 1'b1);
        send_request(dse_pkg::REQ_BIT, 32'h0, 4'd4, 6'd17, 1'b1);
        send_request(dse_pkg::REQ_BIT, 32'h0, 4'd8, 6'd32, 1'b0);
        send_request(dse_pkg::REQ_BIT, 32'h0, 4'd0, 6'd5, 1'b1);
        send_request(dse_pkg::REQ_BIT, 32'h0, 4'd9, 6'd5, 1'b1);
        send_request(dse_pkg::REQ_BIT, 32'h0, 4'd15, 6'd5, 1'b1);
        send_request(dse_pkg::REQ_BIT, 32'h0, 4'd3, 6'd0, 1'b1);
        send_request(dse_pkg::REQ_BIT, 32'h0, 4'd3, 6'd33, 1'b1);
        send_request(dse_pkg::REQ_BIT, 32'h0, 4'd3, 6'd63, 1'b1);
        drain_writes();
    endtask

    task automatic test_all_segments();
        send_request(dse_pkg::REQ_ALL, 32'h0, 4'd0, 6'd0, 1'b1);
        send_request(dse_pkg::REQ_ALL, 32'hffff_ffff, 4'd15, 6'd63, 1'b0);
        send_request(dse_pkg::REQ_UNUSED, 32'hffff_ffff, 4'd2, 6'd2, 1'b1);
        send_request(dse_pkg::REQ_BIT, 32'h0, 4'd2, 6'd3, 1'b1);
        drain_writes();
    endtask

    task automatic test_random_requests();
        for (int i = 0; i < 130; i++) begin
            if (i % 16 == 0) begin
                tx_idle_on = $urandom_range(0, 3) != 0;
                rx_idle_on = $urandom_range(0, 3) != 0;
            end
            send_random_request();
        end
        drain_writes();
    endtask

    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (25) send_random_request();
        drain_writes();
    endtask

    task automatic test_output_backpressure();
        tx_idle_on     = 1'b0;
        rx_idle_on     = 1'b0;
        rx_hold_cycles = HOLD_CYCLES;
        repeat (6) send_random_request();
        drain_writes();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_req_type  <= dse_pkg::REQ_SHOW;
        s_number    <= '0;
        s_com_index <= '0;
        s_seg_index <= '0;
        s_bit_value <= 1'b0;
        for (int i = 0; i < dse_pkg::WORD_COUNT; i++)
            shown_words[i] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_show_number();
        test_segment_bits();
        test_all_segments();
        test_random_requests();
        test_back_to_back();
        test_output_backpressure();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_writes.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : write_checker
        int         wait_cycles;
        reg_write_t want;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            wait_cycles    = rx_hold_cycles + (rx_idle_on ? $urandom_range(0, MAX_GAP) : 0);
            rx_hold_cycles = 0;
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (pending_writes.size() == 0) begin
                report_mismatch("write with nothing pending", m_reg_data, '0);
            end else begin
                want = pending_writes.pop_front();
                if (m_reg_index !== want.idx)
                    report_mismatch("reg_index", m_reg_index, want.idx);
                if (m_reg_data !== want.data)
                    report_mismatch("reg_data", m_reg_data, want.data);
                if (m_last !== want.last)
                    report_mismatch("last", m_last, want.last);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_count <= 0;
        end else if (stall_count >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/dse_pkg.sv
rtl/core/decimal_segment_display_encoder.sv
tb/sv/tb.sv
